// ===== src/pfb_pkg.sv =====
// Shared types, constants and helpers for the page framebuffer line raster unit.
`timescale 1ns / 1ps

package pfb_pkg;

  // Default geometry of the pixel store.
  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 64;
  localparam int unsigned PAGE_COUNT_DEF    = 8;

  // Address width that covers the largest allowed store (32 pages of 256 columns).
  localparam int unsigned ADDR_FULL_W = 13;

  // Command codes.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_POINT = 2'd1,
    OP_LINE  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Current raster point as seen by the sequencer.
  typedef struct packed {
    logic                   on_screen;
    logic                   last;
    logic [ADDR_FULL_W-1:0] addr;
    logic [2:0]             bit_idx;
  } pt_t;

  // Byte address of a column byte: page times row length plus column.
  function automatic logic [ADDR_FULL_W-1:0] lin_addr(input logic [4:0] page,
                                                      input logic [7:0] col,
                                                      input int unsigned width);
    lin_addr = ADDR_FULL_W'(page) * ADDR_FULL_W'(width) + ADDR_FULL_W'(col);
  endfunction

endpackage

// ===== src/pfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; a read and a write to the same address return the old word.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/pfb_line_unit.sv =====
// Bresenham step unit: holds the current point and error term and screens each point.
`timescale 1ns / 1ps

module pfb_line_unit #(
  parameter int unsigned SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned PAGE_COUNT    = pfb_pkg::PAGE_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic [7:0]    x0_i,
  input  logic [7:0]    y0_i,
  input  logic [7:0]    x1_i,
  input  logic [7:0]    y1_i,
  input  logic          step_i,
  output pfb_pkg::pt_t  pt_o,
  output logic [8:0]    count_o
);

  logic [7:0]         x_q, x_d, y_q, y_d;
  logic [7:0]         ex_q, ey_q;
  logic [7:0]         dx_q, dy_q, dx_ld, dy_ld;
  logic               sx_neg_q, sy_neg_q;
  logic signed [11:0] err_q, err_d;
  logic signed [11:0] dx_s, dy_s, e2;
  logic [8:0]         count_q, count_d;

  // Step arithmetic: one error update and coordinate move per step.
  always_comb begin
    dx_s  = $signed({4'b0000, dx_q});
    dy_s  = $signed({4'b0000, dy_q});
    e2    = err_q <<< 1;
    err_d = err_q;
    x_d   = x_q;
    y_d   = y_q;
    if (e2 > -dy_s) begin
      err_d = err_d - dy_s;
      x_d   = x_q + (sx_neg_q ? 8'hFF : 8'h01);
    end
    if (e2 < dx_s) begin
      err_d = err_d + dx_s;
      y_d   = y_q + (sy_neg_q ? 8'hFF : 8'h01);
    end
    count_d = count_q + 9'd1;
  end

  // Absolute deltas of a new line.
  assign dx_ld = (x0_i > x1_i) ? (x0_i - x1_i) : (x1_i - x0_i);
  assign dy_ld = (y0_i > y1_i) ? (y0_i - y1_i) : (y1_i - y0_i);

  // Point and error registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (load_i) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q      <= x0_i;
      y_q      <= y0_i;
      ex_q     <= x1_i;
      ey_q     <= y1_i;
      dx_q     <= dx_ld;
      dy_q     <= dy_ld;
      sx_neg_q <= !(x0_i < x1_i);
      sy_neg_q <= !(y0_i < y1_i);
      err_q    <= $signed({4'b0000, dx_ld}) - $signed({4'b0000, dy_ld});
    end else if (step_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  // Screen test and byte address of the current point.
  always_comb begin
    pt_o.on_screen = ({1'b0, x_q} < 9'(SCREEN_WIDTH))
                  && ({1'b0, y_q} < 9'(SCREEN_HEIGHT))
                  && ({1'b0, y_q[7:3]} < 6'(PAGE_COUNT));
    pt_o.last      = ((x_q == ex_q) && (y_q == ey_q)) || (count_q == 9'd255);
    pt_o.addr      = pfb_pkg::lin_addr(y_q[7:3], x_q, SCREEN_WIDTH);
    pt_o.bit_idx   = y_q[2:0];
  end

  assign count_o = count_q;

endmodule

// ===== src/page_framebuffer_line_raster_unit.sv =====
// Top level: command sequencer, pixel store and result register of the raster unit.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  command | in_valid_i/in_ready_o, op_i .. read_column_i | in
//  result  | out_valid_o/out_ready_i, read_byte_o,        | out
//          | points_visited_o                             |
//
// After reset the store is swept to zero, one byte a cycle, over all PAGE_COUNT*SCREEN_WIDTH
// bytes (1024 by default); no command is taken meanwhile.
// Point and line commands visit their points through a pipelined read-modify-write on
// the store port: a point's byte is read while the previous point's byte is written back.
// A clear command sweeps the whole store to zero; a read fetches one byte.
// One command is in work at a time; a finished word waits in the output register
// while the next command is taken.
`timescale 1ns / 1ps

module page_framebuffer_line_raster_unit #(
  parameter int unsigned SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned PAGE_COUNT    = pfb_pkg::PAGE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [7:0] end_x_i,
  input  logic [7:0] end_y_i,
  input  logic       color_i,
  input  logic [2:0] read_page_i,
  input  logic [6:0] read_column_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o,
  output logic [8:0] points_visited_o
);

  localparam int unsigned Depth = PAGE_COUNT * SCREEN_WIDTH;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CLEAR = 6'b000100,
    ST_DRAW  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  logic         accept;
  pfb_pkg::op_e op;
  logic         rd_in_range;

  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             draw_act_q, draw_act_d;
  logic             color_q, color_d;
  logic             wr_pend_q, wr_pend_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [2:0]       wr_bit_q, wr_bit_d;
  logic             lw_valid_q, lw_valid_d;
  logic [AddrW-1:0] lw_addr_q;
  logic [7:0]       lw_data_q;
  logic [7:0]       res_byte_q, res_byte_d;
  logic [8:0]       res_count_q, res_count_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic [8:0]       out_count_q, out_count_d;

  logic             ram_wr_en, ram_rd_en;
  logic [AddrW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]       ram_wr_data, ram_rd_data;
  logic [7:0]       merge_src, merge_byte, wr_mask;

  logic         ln_load, ln_step;
  logic [7:0]   ln_x1, ln_y1;
  pfb_pkg::pt_t pt;
  logic [8:0]   ln_count;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign op         = pfb_pkg::op_e'(op_i);

  assign rd_in_range = ({3'b000, read_page_i} < 6'(PAGE_COUNT))
                    && ({2'b00, read_column_i} < 9'(SCREEN_WIDTH));

  // Bresenham step unit; a point command is a line of one point.
  assign ln_load = accept && ((op == pfb_pkg::OP_POINT) || (op == pfb_pkg::OP_LINE));
  assign ln_step = (state_q == ST_DRAW) && draw_act_q;
  assign ln_x1   = (op == pfb_pkg::OP_POINT) ? start_x_i : end_x_i;
  assign ln_y1   = (op == pfb_pkg::OP_POINT) ? start_y_i : end_y_i;

  pfb_line_unit #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ln_load),
    .x0_i   (start_x_i),
    .y0_i   (start_y_i),
    .x1_i   (ln_x1),
    .y1_i   (ln_y1),
    .step_i (ln_step),
    .pt_o   (pt),
    .count_o(ln_count)
  );

  // Write half of the read-modify-write; the byte written in the previous cycle
  // is forwarded because that read saw the store before the write.
  assign merge_src  = (lw_valid_q && (lw_addr_q == wr_addr_q)) ? lw_data_q : ram_rd_data;
  assign wr_mask    = 8'h01 << wr_bit_q;
  assign merge_byte = color_q ? (merge_src | wr_mask) : (merge_src & ~wr_mask);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    draw_act_d  = draw_act_q;
    color_d     = color_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_bit_d    = wr_bit_q;
    lw_valid_d  = 1'b0;
    res_byte_d  = res_byte_q;
    res_count_d = res_count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_count_d = out_count_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_addr_q;
    ram_wr_data = 8'h00;
    ram_rd_en   = 1'b0;
    ram_rd_addr = AddrW'(pfb_pkg::lin_addr({2'b00, read_page_i}, {1'b0, read_column_i},
                                           SCREEN_WIDTH));
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_wr_en  = 1'b1;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(Depth - 1)) begin
          clr_addr_d = '0;
          state_d    = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_byte_d  = 8'h00;
          res_count_d = 9'd0;
          case (op)
            pfb_pkg::OP_CLEAR: begin
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            pfb_pkg::OP_POINT: begin
              color_d    = color_i;
              draw_act_d = 1'b1;
              state_d    = ST_DRAW;
            end
            pfb_pkg::OP_LINE: begin
              color_d    = 1'b1;
              draw_act_d = 1'b1;
              state_d    = ST_DRAW;
            end
            pfb_pkg::OP_READ: begin
              ram_rd_en = rd_in_range;
              state_d   = rd_in_range ? ST_READ : ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DRAW: begin
        // Back half: finish the point read in the previous cycle.
        if (wr_pend_q) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = wr_addr_q;
          ram_wr_data = merge_byte;
          lw_valid_d  = 1'b1;
        end
        // Front half: read the byte of the current point.
        if (draw_act_q) begin
          ram_rd_en   = pt.on_screen;
          ram_rd_addr = AddrW'(pt.addr);
          wr_pend_d   = pt.on_screen;
          wr_addr_d   = AddrW'(pt.addr);
          wr_bit_d    = pt.bit_idx;
          if (pt.last) begin
            draw_act_d = 1'b0;
          end
        end else if (!wr_pend_q) begin
          res_count_d = ln_count;
          state_d     = ST_DONE;
        end
      end
      ST_READ: begin
        res_byte_d = ram_rd_data;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_byte_d  = res_byte_q;
          out_count_d = res_count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_addr_q  <= '0;
      draw_act_q  <= 1'b0;
      wr_pend_q   <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      draw_act_q  <= draw_act_d;
      wr_pend_q   <= wr_pend_d;
      lw_valid_q  <= lw_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    color_q     <= color_d;
    wr_addr_q   <= wr_addr_d;
    wr_bit_q    <= wr_bit_d;
    lw_addr_q   <= ram_wr_addr;
    lw_data_q   <= ram_wr_data;
    res_byte_q  <= res_byte_d;
    res_count_q <= res_count_d;
    out_byte_q  <= out_byte_d;
    out_count_q <= out_count_d;
  end

  // Pixel store.
  pfb_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  assign out_valid_o      = out_valid_q;
  assign read_byte_o      = out_byte_q;
  assign points_visited_o = out_count_q;

endmodule
